// ===== rtl/imu_yaw_integrator_pitch_tilt_macros.svh =====
// assertion macros for the imu yaw integrator block
`ifndef IMU_YAW_INTEGRATOR_PITCH_TILT_MACROS_SVH
`define IMU_YAW_INTEGRATOR_PITCH_TILT_MACROS_SVH
`ifndef SYNTHESIS
`define IMU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("imu yaw assertion failed");
`define IMU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("imu yaw assertion failed");
`else
`define IMU_ASSERT(label, clk, rst, prop)
`define IMU_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/imu_yaw_pkg.sv =====
// shared types, constants and tables of the imu yaw integrator
`timescale 1ns / 1ps
`default_nettype none
package imu_yaw_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DIV_BITS         = 36;
  localparam int ITER_W           = $clog2(DIV_BITS);
  localparam int ATAN_IDX_W       = 5;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [28:0]        YAW_K           = 29'd314410567;
  localparam logic signed [26:0] Z180            = 27'sd11796480;
  localparam logic signed [26:0] PITCH_MAX       = 27'sd46080;
  localparam logic [15:0]        DEADBAND_RST    = 16'd512;
  localparam logic [12:0]        CAL_SAMPLES_RST = 13'd256;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES = 2'd1;

  typedef enum logic [1:0] {
    CMD_GYRO    = 2'd0,
    CMD_ACCEL   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    MUL_RATE_DT,
    MUL_LO_K,
    MUL_HI_K
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CAL_ACC,
    ST_CAL_CHECK,
    ST_DIV,
    ST_DIV_END,
    ST_PREP,
    ST_MUL_P,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_YAW,
    ST_CORDIC_INIT,
    ST_CORDIC,
    ST_PITCH,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic              latch;
    logic              restart;
    logic              cal_acc;
    logic              div_init;
    logic              div_step;
    logic              div_done;
    logic              prep;
    logic              mul_en;
    mul_sel_t          mul_sel;
    logic              sum_en;
    logic              yaw_upd;
    logic              cordic_init;
    logic              cordic_step;
    logic              pitch_wr;
    logic              emit;
    logic [ITER_W-1:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t code;
    logic      calib_active;
    logic      cal_reached;
  } dp_stat_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_deg16(input logic [ATAN_IDX_W-1:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/imu_yaw_ctrl.sv =====
// controller state machine of the imu yaw integrator
`timescale 1ns / 1ps
`default_nettype none
module imu_yaw_ctrl #(
  parameter int CORDIC_STEPS = imu_yaw_pkg::CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  imu_yaw_pkg::dp_stat_t  dp_stat,
  output imu_yaw_pkg::dp_cmd_t   dp_cmd
);
  import imu_yaw_pkg::*;

  localparam logic [ITER_W-1:0] DIV_LAST    = ITER_W'(DIV_BITS - 1);
  localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(CORDIC_STEPS - 1);

  ctrl_state_t       state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      iter      <= iter_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    iter_next      = iter;
    dp_cmd         = '0;
    dp_cmd.mul_sel = MUL_RATE_DT;
    dp_cmd.iter    = iter;
    out_valid_next = out_stall ? out_valid : 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          dp_cmd.latch = 1'b1;
          state_next   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (dp_stat.code)
          CMD_GYRO:    state_next = dp_stat.calib_active ? ST_CAL_ACC : ST_PREP;
          CMD_ACCEL:   state_next = ST_CORDIC_INIT;
          CMD_RESTART: begin
            dp_cmd.restart = 1'b1;
            state_next     = ST_EMIT;
          end
          default:     state_next = ST_EMIT;
        endcase
      end
      ST_CAL_ACC: begin
        dp_cmd.cal_acc = 1'b1;
        state_next     = ST_CAL_CHECK;
      end
      ST_CAL_CHECK: begin
        if (dp_stat.cal_reached) begin
          dp_cmd.div_init = 1'b1;
          iter_next       = '0;
          state_next      = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        dp_cmd.div_step = 1'b1;
        if (iter == DIV_LAST) begin
          state_next = ST_DIV_END;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      ST_DIV_END: begin
        dp_cmd.div_done = 1'b1;
        state_next      = ST_EMIT;
      end
      ST_PREP: begin
        dp_cmd.prep = 1'b1;
        state_next  = ST_MUL_P;
      end
      ST_MUL_P: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_RATE_DT;
        state_next     = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_LO_K;
        state_next     = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_HI_K;
        state_next     = ST_SUM;
      end
      ST_SUM: begin
        dp_cmd.sum_en = 1'b1;
        state_next    = ST_YAW;
      end
      ST_YAW: begin
        dp_cmd.yaw_upd = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_CORDIC_INIT: begin
        dp_cmd.cordic_init = 1'b1;
        iter_next          = '0;
        state_next         = ST_CORDIC;
      end
      ST_CORDIC: begin
        dp_cmd.cordic_step = 1'b1;
        if (iter == CORDIC_LAST) begin
          state_next = ST_PITCH;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      ST_PITCH: begin
        dp_cmd.pitch_wr = 1'b1;
        state_next      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          dp_cmd.emit    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/imu_yaw_dp.sv =====
// datapath of the imu yaw integrator: state, divider, multiplier, cordic
`timescale 1ns / 1ps
`default_nettype none
module imu_yaw_dp (
  input  logic                                      clk,
  input  logic                                      rst,
  input  imu_yaw_pkg::dp_cmd_t                      dp_cmd,
  output imu_yaw_pkg::dp_stat_t                     dp_stat,
  input  logic                                      cfg_we,
  input  logic [imu_yaw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [imu_yaw_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [1:0]                                cmd,
  input  logic signed [23:0]                        gyro_rate,
  input  logic [31:0]                               timestamp_us,
  input  logic signed [15:0]                        accel_y,
  input  logic signed [15:0]                        accel_z,
  output logic signed [47:0]                        yaw_angle,
  output logic signed [16:0]                        pitch_angle,
  output logic                                      calibrating,
  output logic signed [23:0]                        gyro_bias
);
  import imu_yaw_pkg::*;

  // latched item
  cmd_code_t          cmd_q;
  logic signed [23:0] rate_q;
  logic [31:0]        ts_q;
  logic signed [15:0] ay_q;
  logic signed [15:0] az_q;

  // configuration
  logic [15:0] deadband;
  logic [12:0] cal_samples;

  // architectural state
  logic [47:0]        yaw_acc;
  logic signed [16:0] pitch_val;
  logic signed [23:0] bias_val;
  logic [31:0]        last_time;
  logic signed [36:0] calib_sum;
  logic [12:0]        calib_count;
  logic               calib_active;

  // divider
  logic [12:0] div_rem;
  logic [35:0] div_quo;
  logic        div_neg;

  // yaw integration
  logic        corr_neg;
  logic [24:0] mag_q;
  logic [31:0] dt_q;
  logic [55:0] prod_p;
  logic [60:0] prod_lo;
  logic [47:0] prod_hi;
  logic [29:0] lo_rnd_q;
  logic [47:0] delta;

  // cordic
  logic signed [35:0] cx;
  logic signed [35:0] cy;
  logic signed [26:0] cz;

  logic [12:0]        cal_target;
  logic signed [24:0] corr;
  logic [24:0]        corr_mag;
  logic [24:0]        mag_db;
  logic [36:0]        sum_abs;
  logic [14:0]        div_trial;
  logic               div_fit;
  logic [13:0]        div_part;
  logic [35:0]        quo_signed;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic [61:0]        lo_rnd;
  logic [ATAN_IDX_W-1:0] shamt;
  logic signed [35:0] xs;
  logic signed [35:0] ys;
  logic signed [26:0] atan_v;
  logic signed [35:0] ax;
  logic signed [35:0] ayv;
  logic signed [26:0] zr;
  logic signed [26:0] zs;
  logic signed [16:0] pitch_sat;

  assign cal_target           = (cal_samples == 13'd0) ? 13'd1 : cal_samples;
  assign dp_stat.code         = cmd_q;
  assign dp_stat.calib_active = calib_active;
  assign dp_stat.cal_reached  = (calib_count >= cal_target);

  always_comb begin
    corr     = 25'(rate_q) - 25'(bias_val);
    corr_mag = corr[24] ? 25'(-corr) : 25'(corr);
    mag_db   = (corr_mag < {9'd0, deadband}) ? 25'd0 : corr_mag;
    sum_abs  = calib_sum[36] ? 37'(-calib_sum) : 37'(calib_sum);
  end

  always_comb begin
    div_part   = {div_rem, div_quo[35]};
    div_trial  = {1'b0, div_part} - {2'b00, calib_count};
    div_fit    = !div_trial[14];
    quo_signed = div_neg ? 36'(-div_quo) : div_quo;
  end

  always_comb begin
    case (dp_cmd.mul_sel)
      MUL_RATE_DT: begin
        mul_a = {7'd0, mag_q};
        mul_b = dt_q;
      end
      MUL_LO_K: begin
        mul_a = prod_p[31:0];
        mul_b = {3'd0, YAW_K};
      end
      MUL_HI_K: begin
        mul_a = {8'd0, prod_p[55:32]};
        mul_b = {3'd0, YAW_K};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p  = mul_a * mul_b;
    lo_rnd = {1'b0, prod_lo} + 62'h0000_0000_8000_0000;
  end

  always_comb begin
    shamt     = dp_cmd.iter[ATAN_IDX_W-1:0];
    xs        = cx >>> shamt;
    ys        = cy >>> shamt;
    atan_v    = signed'({5'd0, atan_deg16(shamt)});
    ax        = signed'({{4{az_q[15]}}, az_q, 16'd0});
    ayv       = signed'({{4{ay_q[15]}}, ay_q, 16'd0});
    zr        = cz + 27'sd128;
    zs        = zr >>> 8;
    if (zs > PITCH_MAX) begin
      pitch_sat = 17'(PITCH_MAX);
    end else if (zs < -PITCH_MAX) begin
      pitch_sat = 17'(-PITCH_MAX);
    end else begin
      pitch_sat = zs[16:0];
    end
  end

  // item latch and working registers
  always_ff @(posedge clk) begin
    if (dp_cmd.latch) begin
      cmd_q  <= cmd_code_t'(cmd);
      rate_q <= gyro_rate;
      ts_q   <= timestamp_us;
      ay_q   <= accel_y;
      az_q   <= accel_z;
    end
    if (dp_cmd.div_init) begin
      div_rem <= '0;
      div_quo <= sum_abs[35:0];
      div_neg <= calib_sum[36];
    end else if (dp_cmd.div_step) begin
      div_rem <= div_fit ? div_trial[12:0] : div_part[12:0];
      div_quo <= {div_quo[34:0], div_fit};
    end
    if (dp_cmd.prep) begin
      corr_neg <= corr[24];
      mag_q    <= mag_db;
      dt_q     <= ts_q - last_time;
    end
    if (dp_cmd.mul_en) begin
      case (dp_cmd.mul_sel)
        MUL_RATE_DT: prod_p <= mul_p[55:0];
        MUL_LO_K:    prod_lo <= mul_p[60:0];
        MUL_HI_K: begin
          prod_hi  <= mul_p[47:0];
          lo_rnd_q <= lo_rnd[61:32];
        end
        default: ;
      endcase
    end
    if (dp_cmd.sum_en) begin
      delta <= prod_hi + {18'd0, lo_rnd_q};
    end
    if (dp_cmd.cordic_init) begin
      if (az_q < 0) begin
        cx <= -ax;
        cy <= -ayv;
        cz <= (ay_q >= 0) ? Z180 : -Z180;
      end else begin
        cx <= ax;
        cy <= ayv;
        cz <= '0;
      end
    end else if (dp_cmd.cordic_step) begin
      if (cy > 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_v;
      end else if (cy < 0) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_v;
      end
    end
    if (dp_cmd.emit) begin
      yaw_angle   <= signed'(yaw_acc);
      pitch_angle <= pitch_val;
      calibrating <= calib_active;
      gyro_bias   <= bias_val;
    end
  end

  // configuration and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband     <= DEADBAND_RST;
      cal_samples  <= CAL_SAMPLES_RST;
      yaw_acc      <= '0;
      pitch_val    <= '0;
      bias_val     <= '0;
      last_time    <= '0;
      calib_sum    <= '0;
      calib_count  <= '0;
      calib_active <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEADBAND:    deadband <= cfg_data;
          REG_CAL_SAMPLES: cal_samples <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (dp_cmd.restart) begin
        yaw_acc      <= '0;
        pitch_val    <= '0;
        bias_val     <= '0;
        calib_sum    <= '0;
        calib_count  <= '0;
        calib_active <= 1'b1;
      end
      if (dp_cmd.cal_acc) begin
        calib_sum   <= calib_sum + 37'(rate_q);
        calib_count <= calib_count + 13'd1;
      end
      if (dp_cmd.div_done) begin
        bias_val     <= signed'(quo_signed[23:0]);
        last_time    <= ts_q;
        calib_active <= 1'b0;
      end
      if (dp_cmd.prep) begin
        last_time <= ts_q;
      end
      if (dp_cmd.yaw_upd) begin
        yaw_acc <= corr_neg ? (yaw_acc - delta) : (yaw_acc + delta);
      end
      if (dp_cmd.pitch_wr) begin
        pitch_val <= pitch_sat;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/imu_yaw_integrator_pitch_tilt.sv =====
// top level of the imu yaw integrator with accelerometer pitch
//
// Input channel (in_valid / in_stall) takes one command beat: a gyro-Z sample
// with its microsecond timestamp, an accelerometer Y/Z sample, or a restart
// of the bias calibration. Each beat gives exactly one result beat on the
// output channel (out_valid / out_stall) carrying yaw, pitch, the
// calibrating flag and the gyro bias as they stand after that command.
// A restart or an unused code goes straight to the result; a calibration
// sample is added to the sum, and the sample that closes the calibration
// also runs a bit-serial divider; a yaw integration uses one shared 32x32
// multiplier three times; an accel sample runs the cordic (one cordic
// iteration per cycle). One item is worked on at a time; the next
// beat is taken the cycle after the result enters the output register.
// A result waiting under out_stall holds the output register; the next item
// is accepted and worked on meanwhile and waits only to load its result.
// The configuration port (cfg_valid / cfg_ready) is always ready.
// Synchronous reset clears yaw, pitch, bias and the timestamp, starts a
// calibration and loads the default deadband and sample count.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_yaw_integrator_pitch_tilt_macros.svh"
module imu_yaw_integrator_pitch_tilt #(
  parameter int CORDIC_STEPS = imu_yaw_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic signed [23:0]                  gyro_rate,
  input  logic [31:0]                         timestamp_us,
  input  logic signed [15:0]                  accel_y,
  input  logic signed [15:0]                  accel_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [47:0]                  yaw_angle,
  output logic signed [16:0]                  pitch_angle,
  output logic                                calibrating,
  output logic signed [23:0]                  gyro_bias,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [imu_yaw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imu_yaw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import imu_yaw_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  imu_yaw_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  imu_yaw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .dp_stat     (dp_stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .gyro_rate   (gyro_rate),
    .timestamp_us(timestamp_us),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .yaw_angle   (yaw_angle),
    .pitch_angle (pitch_angle),
    .calibrating (calibrating),
    .gyro_bias   (gyro_bias)
  );

  `IMU_ASSERT(a_emit_free, clk, rst, dp_cmd.emit |-> (!out_valid || !out_stall))
  `IMU_ASSERT(a_latch_on_beat, clk, rst, dp_cmd.latch |-> (in_valid && !in_stall))
  `IMU_ASSERT(a_one_action, clk, rst, $onehot0({dp_cmd.latch, dp_cmd.cal_acc, dp_cmd.div_step, dp_cmd.mul_en, dp_cmd.cordic_step, dp_cmd.emit}))
  `IMU_ASSERT(a_restart_result, clk, rst, (dp_cmd.emit && (dp_stat.code == CMD_RESTART)) |=> (calibrating && (yaw_angle == 48'sd0) && (gyro_bias == 24'sd0)))
  `IMU_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid)

endmodule
`default_nettype wire

// ===== verif/imu_attitude_checker.sv =====
`timescale 1ns / 1ps
// checker module for the imu yaw integrator: tracks the block state and compares result beats
module imu_attitude_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic signed [23:0]                  gyro_rate,
  input  logic [31:0]                         timestamp_us,
  input  logic signed [15:0]                  accel_y,
  input  logic signed [15:0]                  accel_z,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [47:0]                  yaw_angle,
  input  logic signed [16:0]                  pitch_angle,
  input  logic                                calibrating,
  input  logic signed [23:0]                  gyro_bias,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [imu_yaw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imu_yaw_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  results_seen
);
  import imu_yaw_pkg::*;

  localparam longint unsigned YAW_SCALE = 64'd314410567;
  localparam longint HALF_TURN = 180 * 65536;
  localparam longint PITCH_LIMIT = 46080;
  localparam int TILT_STEPS = (CORDIC_STEPS_DEF < 24) ? CORDIC_STEPS_DEF : 24;

  typedef struct packed {
    logic [47:0] yaw;
    logic [16:0] pitch;
    logic        calib;
    logic [23:0] bias;
  } attitude_t;

  // atan(2^-i) in 1/65536 degree
  longint atan_step_deg [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  attitude_t          expected_attitude [$];
  attitude_t          want;
  logic [47:0]        yaw_acc;
  logic signed [16:0] pitch_q;
  logic signed [23:0] bias_q;
  logic [31:0]        last_ts;
  longint             cal_sum;
  logic [12:0]        cal_cnt;
  logic               cal_on;
  logic [15:0]        deadband_q;
  logic [12:0]        cal_target;

  function automatic logic signed [16:0] tilt_pitch(input logic signed [15:0] ay,
                                                    input logic signed [15:0] az);
    longint x, y, z, xs, ys, r;
    int i;
    x = longint'(az) * 65536;
    y = longint'(ay) * 65536;
    z = 0;
    if (ay == 0 && az == 0) return '0;
    // left half plane: rotate by half a turn first
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (i = 0; i < TILT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step_deg[i];
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step_deg[i];
      end
    end
    r = (z + 128) >>> 8;
    if (r > PITCH_LIMIT) r = PITCH_LIMIT;
    if (r < -PITCH_LIMIT) r = -PITCH_LIMIT;
    return r[16:0];
  endfunction

  task automatic clear_attitude();
    yaw_acc = '0;
    pitch_q = '0;
    bias_q  = '0;
    cal_sum = 0;
    cal_cnt = '0;
    cal_on  = 1'b1;
  endtask

  task automatic predict_attitude(input logic [1:0] code, input logic signed [23:0] rate,
                                  input logic [31:0] ts, input logic signed [15:0] ay,
                                  input logic signed [15:0] az);
    logic [12:0] goal;
    longint corr;
    longint unsigned mag, dt, prod, delta;
    case (code)
      CMD_GYRO: begin
        if (cal_on) begin
          goal = (cal_target == '0) ? 13'd1 : cal_target;
          cal_sum = cal_sum + longint'(rate);
          cal_cnt = cal_cnt + 13'd1;
          if (cal_cnt >= goal) begin
            bias_q  = 24'(cal_sum / longint'(cal_cnt));
            last_ts = ts;
            cal_on  = 1'b0;
          end
        end else begin
          corr = longint'(rate) - longint'(bias_q);
          mag = (corr < 0) ? -corr : corr;
          dt = {32'd0, ts - last_ts};
          last_ts = ts;
          if (mag < {48'd0, deadband_q}) mag = 0;
          prod = mag * dt;
          delta = (prod >> 32) * YAW_SCALE
                + (((prod & 64'hFFFF_FFFF) * YAW_SCALE + 64'h8000_0000) >> 32);
          if (corr < 0) yaw_acc = yaw_acc - delta[47:0];
          else yaw_acc = yaw_acc + delta[47:0];
        end
      end
      CMD_ACCEL: pitch_q = tilt_pitch(ay, az);
      CMD_RESTART: clear_attitude();
      default: ;
    endcase
    expected_attitude.push_back({yaw_acc, pitch_q, cal_on, bias_q});
  endtask

  task automatic check_field(input string name, input logic [47:0] want_v,
                             input logic [47:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_attitude();
      last_ts = '0;
      deadband_q = DEADBAND_RST;
      cal_target = CAL_SAMPLES_RST;
      expected_attitude.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DEADBAND) deadband_q = cfg_data;
        else if (cfg_index == REG_CAL_SAMPLES) cal_target = cfg_data[12:0];
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_attitude.size() == 0) begin
          $display("%0t: result beat with nothing expected, yaw %h", $time, yaw_angle);
          fail_count++;
        end else begin
          want = expected_attitude.pop_front();
          check_field("yaw_angle", want.yaw, yaw_angle);
          check_field("pitch_angle", {31'd0, want.pitch}, {31'd0, pitch_angle});
          check_field("calibrating", {47'd0, want.calib}, {47'd0, calibrating});
          check_field("gyro_bias", {24'd0, want.bias}, {24'd0, gyro_bias});
        end
      end
      if (in_valid && !in_stall)
        predict_attitude(cmd, gyro_rate, timestamp_us, accel_y, accel_z);
    end
    pending = expected_attitude.size();
  end

endmodule

// ===== verif/tb_imu_yaw_integrator_pitch_tilt.sv =====
`timescale 1ns / 1ps
// testbench top for the imu yaw integrator: stimulus, output stalls and verdict
module tb_imu_yaw_integrator_pitch_tilt;
  import imu_yaw_pkg::*;

  localparam int CYCLE_LIMIT  = 900000;
  localparam int RANDOM_ITEMS = 850;
  localparam int LONG_HOLD    = 400;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             cmd = CMD_GYRO;
  logic signed [23:0]     gyro_rate = '0;
  logic [31:0]            timestamp_us = '0;
  logic signed [15:0]     accel_y = '0;
  logic signed [15:0]     accel_z = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [47:0]     yaw_angle;
  logic signed [16:0]     pitch_angle;
  logic                   calibrating;
  logic signed [23:0]     gyro_bias;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_DEADBAND;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     fail_count;
  int                     pending;
  int                     results_seen;

  bit          calm = 1'b0;
  int          hold_reqs = 0;
  int          holds_done = 0;
  int          stall_left = 0;
  int          cycle_count;
  logic [31:0] ts_now = '0;
  int          n_gyro = 0;
  int          n_accel = 0;
  int          n_restart = 0;
  int          n_nop = 0;
  int          n_settings = 0;

  imu_yaw_integrator_pitch_tilt dut (.*);
  imu_attitude_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] next_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 75) return $urandom_range(1, 2000);
    if (r < 95) return $urandom_range(2001, 200000);
    return $urandom();
  endfunction

  function automatic logic signed [15:0] pick_accel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return -16'sd32768;
      2: return 16'sd32767;
      3: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int noise(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(input logic [1:0] c, input logic signed [23:0] r,
                           input logic [31:0] t, input logic signed [15:0] ay,
                           input logic signed [15:0] az);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    gyro_rate <= r;
    timestamp_us <= t;
    accel_y <= ay;
    accel_z <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    case (c)
      CMD_GYRO: n_gyro++;
      CMD_ACCEL: n_accel++;
      CMD_RESTART: n_restart++;
      default: n_nop++;
    endcase
  endtask

  task automatic send_gyro(input logic signed [23:0] r, input logic [31:0] dt);
    ts_now = ts_now + dt;
    send_beat(CMD_GYRO, r, ts_now, 16'($urandom()), 16'($urandom()));
  endtask

  task automatic send_accel(input logic signed [15:0] ay, input logic signed [15:0] az);
    send_beat(CMD_ACCEL, 24'($urandom()), $urandom(), ay, az);
  endtask

  task automatic send_ctrl(input logic [1:0] c);
    send_beat(c, 24'($urandom()), $urandom(), 16'($urandom()), 16'($urandom()));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_regs(input logic [15:0] db, input logic [15:0] cs);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEADBAND;
    cfg_data <= db;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_CAL_SAMPLES;
    cfg_data <= cs;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // output side stalls
  always begin
    @(negedge clk);
    if (hold_reqs != holds_done) begin
      holds_done++;
      out_stall <= 1'b1;
      repeat (LONG_HOLD) @(negedge clk);
    end else begin
      if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else out_stall <= 1'b0;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int base;
    int phase;
    int goal;
    int center;
    int span;
    int r;
    logic [15:0] db;
    logic [15:0] cs;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset settings, pitch corners, unused code
    send_ctrl(CMD_NOP);
    send_accel(16'sd0, 16'sd0);
    send_accel(16'sd0, -16'sd5);
    send_accel(-16'sd32768, -16'sd32768);
    send_accel(16'sd32767, 16'sd0);
    send_accel(-16'sd32768, 16'sd0);
    send_accel(16'sd0, 16'sd32767);
    send_accel(-16'sd1, -16'sd32768);
    send_accel(16'sd32767, -16'sd32768);
    send_gyro(-24'sd8388608, 32'd1000);
    send_ctrl(CMD_RESTART);

    // single-sample calibration, largest rate and interval
    set_regs(16'd0, 16'd1);
    send_gyro(24'sd8388607, 32'd50);
    send_gyro(-24'sd8388608, 32'hFFFF_FFFF);
    send_gyro(24'sd0, 32'd0);
    send_gyro(24'sd8388607, 32'd1234);
    send_ctrl(CMD_RESTART);

    // zero target acts as one, widest deadband edges
    set_regs(16'hFFFF, 16'd0);
    send_gyro(-24'sd8388608, 32'd10);
    send_gyro(-24'sd8388608 + 24'sd65534, 32'd777);
    send_gyro(-24'sd8388608 + 24'sd65535, 32'd777);
    send_gyro(24'sd8388607, 32'hFFFF_FFFF);
    send_ctrl(CMD_RESTART);

    // a long target, then lowered mid-calibration (upper data bits ignored)
    set_regs(16'd512, 16'd4096);
    repeat (10) send_gyro(24'($urandom()), next_dt());
    set_regs(16'd512, 16'hE005);
    send_gyro(24'($urandom()), next_dt());
    send_gyro(24'($urandom()), next_dt());

    base = n_gyro + n_accel + n_restart + n_nop;
    phase = 0;
    while (n_gyro + n_accel + n_restart + n_nop - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: db = '0;
        1: db = 16'hFFFF;
        2, 3: db = 16'($urandom_range(0, 2048));
        default: db = 16'($urandom());
      endcase
      case ($urandom_range(0, 7))
        0: cs = '0;
        1: cs = 16'($urandom_range(20, 40));
        2: cs = 16'($urandom_range(0, 7) << 13) | 16'($urandom_range(1, 6));
        default: cs = 16'($urandom_range(1, 8));
      endcase
      set_regs(db, cs);
      calm = ($urandom_range(0, 3) == 0);
      goal = (cs[12:0] == 13'd0) ? 1 : int'(cs[12:0]);
      center = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      span = int'(db) + 8;
      if ($urandom_range(0, 4) != 0) send_ctrl(CMD_RESTART);
      repeat (goal) send_gyro(24'(center + noise(span)), next_dt());
      if (phase == 2) hold_reqs++;
      repeat ($urandom_range(15, 40)) begin
        r = $urandom_range(0, 99);
        if (r < 45) send_gyro(24'(center + noise(span)), next_dt());
        else if (r < 60) send_gyro(24'(center + noise(70000)), next_dt());
        else if (r < 66) send_gyro(24'($urandom()), next_dt());
        else if (r < 88) send_accel(pick_accel(), pick_accel());
        else if (r < 94) send_ctrl(CMD_RESTART);
        else send_ctrl(CMD_NOP);
      end
      phase++;
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    drain();
    repeat (60) @(posedge clk);
    $display("summary: %0d beats in (%0d gyro, %0d accel, %0d restart, %0d unused), %0d results",
             n_gyro + n_accel + n_restart + n_nop, n_gyro, n_accel, n_restart, n_nop,
             results_seen);
    $display("summary: %0d register settings, %0d long output holds, %0d mismatches",
             n_settings, holds_done, fail_count);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
